FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define PMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define PMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pmd_pkg.sv
// ---------------------------------------------------------------------------
// Mouse packet decoder package
// Event codes, packet descriptor type and queue sizing for the decoder modules.
// ---------------------------------------------------------------------------
package pmd_pkg;

  // Event codes; each code is also the bit position in the event mask
  typedef enum logic [2:0] {
    KIND_MOVE_X = 3'd0,
    KIND_MOVE_Y = 3'd1,
    KIND_LEFT   = 3'd2,
    KIND_RIGHT  = 3'd3,
    KIND_MIDDLE = 3'd4,
    KIND_SYNC   = 3'd5
  } pmd_kind_t;

  localparam int unsigned EVENT_COUNT = 6;

  // Header byte bits
  localparam logic [7:0] SYNC_BIT      = 8'h08;
  localparam logic [7:0] OVERFLOW_BITS = 8'hc0;
  localparam logic [7:0] SRC_LEFT      = 8'h01;
  localparam logic [7:0] SRC_RIGHT     = 8'h02;
  localparam logic [7:0] SRC_MIDDLE    = 8'h04;

  // Held button positions
  localparam int unsigned HELD_LEFT   = 0;
  localparam int unsigned HELD_MIDDLE = 1;
  localparam int unsigned HELD_RIGHT  = 2;

  localparam int unsigned PMD_QUEUE_DEPTH = 2;

  // One decoded packet, waiting to be turned into events
  typedef struct packed {
    logic [EVENT_COUNT-1:0] events;
    logic signed [8:0]      move_x;
    logic signed [8:0]      move_y;
    logic [2:0]             buttons;
  } pmd_packet_t;

endpackage

FILE: sv/pmd_if.sv
// ---------------------------------------------------------------------------
// Mouse packet decoder channels
// Valid/ready channels for raw bytes in and decoded events out.
// ---------------------------------------------------------------------------
interface pmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

interface pmd_event_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_kind;
  logic signed [8:0] event_value;
  logic              last_event;

  modport source (output valid, output event_kind, output event_value,
                  output last_event, input ready);
  modport sink   (input valid, input event_kind, input event_value,
                  input last_event, output ready);
endinterface

FILE: sv/pmd_front.sv
// ---------------------------------------------------------------------------
// Mouse packet decoder front end
// Assembles three-byte packets, filters them and queues a packet descriptor.
// ---------------------------------------------------------------------------
module pmd_front
  import pmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  pmd_byte_if.sink    byte_in,
  input  logic        push_ready,
  output logic        push_valid,
  output pmd_packet_t push_data
);

  logic        decode_enable;
  logic [1:0]  position;
  logic [1:0]  position_next;
  logic [2:0]  prev_buttons;
  logic [2:0]  prev_buttons_next;
  logic [7:0]  header;
  logic [7:0]  x_byte;
  logic        accept;
  logic [2:0]  buttons;
  logic [2:0]  changed;
  logic signed [8:0] move_x;
  logic signed [8:0] move_y;
  logic        worth_report;

  assign byte_in.ready = push_ready;
  assign accept        = byte_in.valid && byte_in.ready;

  // Decode the completed packet from the stored bytes and the current byte
  always_comb begin
    buttons              = '0;
    buttons[HELD_LEFT]   = |(header & SRC_LEFT);
    buttons[HELD_MIDDLE] = |(header & SRC_MIDDLE);
    buttons[HELD_RIGHT]  = |(header & SRC_RIGHT);
    changed              = buttons ^ prev_buttons;
    move_x               = {x_byte[7], x_byte};
    move_y               = 9'sd0 - $signed({byte_in.mouse_byte[7], byte_in.mouse_byte});
    worth_report         = (move_x != '0) || (move_y != '0) || (changed != '0);
  end

  always_comb begin
    position_next     = position;
    prev_buttons_next = prev_buttons;
    push_valid        = 1'b0;
    push_data.events  = '0;
    push_data.events[KIND_MOVE_X] = (move_x != '0);
    push_data.events[KIND_MOVE_Y] = (move_y != '0);
    push_data.events[KIND_LEFT]   = changed[HELD_LEFT];
    push_data.events[KIND_RIGHT]  = changed[HELD_RIGHT];
    push_data.events[KIND_MIDDLE] = changed[HELD_MIDDLE];
    push_data.events[KIND_SYNC]   = 1'b1;
    push_data.move_x  = move_x;
    push_data.move_y  = move_y;
    push_data.buttons = buttons;
    if (cfg_write_en && !cfg_write_data) begin
      position_next = 2'd0;
    end else if (accept) begin
      if (!decode_enable) begin
        position_next = 2'd0;
      end else if (position == 2'd0) begin
        if ((byte_in.mouse_byte & SYNC_BIT) != '0) begin
          position_next = 2'd1;
        end
      end else if (position == 2'd1) begin
        position_next = 2'd2;
      end else begin
        position_next = 2'd0;
        if (((header & OVERFLOW_BITS) == '0) && worth_report) begin
          push_valid        = 1'b1;
          prev_buttons_next = buttons;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b0;
      position      <= 2'd0;
      prev_buttons  <= '0;
    end else begin
      if (cfg_write_en) begin
        decode_enable <= cfg_write_data;
      end
      position     <= position_next;
      prev_buttons <= prev_buttons_next;
    end
  end

  // Packet bytes: payload only, always written before use
  always_ff @(posedge clk) begin
    if (accept && decode_enable && !(cfg_write_en && !cfg_write_data)) begin
      if (position == 2'd0) begin
        header <= byte_in.mouse_byte;
      end
      if (position == 2'd1) begin
        x_byte <= byte_in.mouse_byte;
      end
    end
  end

endmodule

FILE: sv/pmd_queue.sv
// ---------------------------------------------------------------------------
// Mouse packet decoder descriptor queue
// Short FIFO that decouples packet assembly from event issue.
// ---------------------------------------------------------------------------
module pmd_queue
  import pmd_pkg::*;
#(
  parameter int unsigned DEPTH = PMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  pmd_packet_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output pmd_packet_t pop_data
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pmd_packet_t      entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/pmd_back.sv
// ---------------------------------------------------------------------------
// Mouse packet decoder back end
// Walks a packet's event mask; one event request per cycle unless stalled.
// ---------------------------------------------------------------------------
module pmd_back
  import pmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  pmd_packet_t pop_data,
  pmd_event_if.source event_out
);

  `include "assert_macros.svh"

  logic [EVENT_COUNT-1:0] pending;
  logic [EVENT_COUNT-1:0] pending_next;
  logic [EVENT_COUNT-1:0] pending_after;
  logic [EVENT_COUNT-1:0] sel;
  pmd_packet_t            cur;
  logic                   out_free;
  logic                   emit;
  pmd_kind_t              kind;
  logic signed [8:0]      value;
  logic                   load;

  assign out_free = !event_out.valid || event_out.ready;
  assign emit     = out_free && (pending != '0);
  assign sel      = pending & (~pending + 1'b1);

  // Lowest pending bit gives the next event in report order
  always_comb begin
    kind = KIND_SYNC;
    for (int i = EVENT_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        kind = pmd_kind_t'(3'(i));
      end
    end
  end

  always_comb begin
    unique case (kind)
      KIND_MOVE_X: value = cur.move_x;
      KIND_MOVE_Y: value = cur.move_y;
      KIND_LEFT:   value = {8'd0, cur.buttons[HELD_LEFT]};
      KIND_RIGHT:  value = {8'd0, cur.buttons[HELD_RIGHT]};
      KIND_MIDDLE: value = {8'd0, cur.buttons[HELD_MIDDLE]};
      KIND_SYNC:   value = '0;
      default:     value = '0;
    endcase
  end

  // Chain the next packet straight after the closing event
  always_comb begin
    pending_after = emit ? (pending & ~sel) : pending;
    load          = (pending_after == '0) && pop_valid;
    pending_next  = load ? pop_data.events : pending_after;
  end

  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= '0;
      event_out.valid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (emit) begin
        event_out.valid <= 1'b1;
      end else if (event_out.ready) begin
        event_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_data;
    end
    if (emit) begin
      event_out.event_kind  <= kind;
      event_out.event_value <= value;
      event_out.last_event  <= (kind == KIND_SYNC);
    end
  end

  `PMD_ASSERT(a_last_is_sync, !event_out.valid || (event_out.last_event == (event_out.event_kind == KIND_SYNC)), "last_event out of step with sync kind")
  `PMD_ASSERT(a_sync_closes, (pending == '0) || pending[KIND_SYNC], "pending packet lost its sync event")
  `PMD_ASSERT_NEXT(a_button_level, emit && (kind == KIND_LEFT || kind == KIND_RIGHT || kind == KIND_MIDDLE), event_out.event_value[8:1] == '0, "button event value not a level")

endmodule

FILE: sv/ps2_mouse_packet_decoder_unit.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Turns auxiliary-channel bytes into movement, button and sync events.
// ---------------------------------------------------------------------------
// Usage:
//   byte_in   - raw mouse bytes, one request per accepted byte (valid/ready).
//   event_out - decoded events: kind, signed value and a last marker that
//               closes each packet's report with a sync event.
//   cfg_write_en / cfg_write_data - decode enable; writing 0 also clears the
//               packet position. Write only while the block is idle.
// Path: once a packet's third byte is accepted, its descriptor passes the
//   queue and the back end's pending mask into the output register; events
//   follow one per cycle while event_out is not stalled, up to six per packet.
// Throughput: a byte can be accepted every cycle while the queue is not full.
//   The back end issues one event per cycle unless stalled, two to six per
//   packet; the descriptor queue (QUEUE_DEPTH packets) absorbs bursts.
// Reset: decoding is disabled, the packet position and the held buttons
//   clear, the queue empties and no event is offered.
// Stall: while event_out.ready is low the current event holds in the output
//   register; the back end stops, the queue fills, and byte_in.ready drops
//   only once the queue is full.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_decoder_unit
  import pmd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = PMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  pmd_byte_if.sink    byte_in,
  pmd_event_if.source event_out
);

  // Descriptor hand-off: front end to queue
  logic        push_valid;
  logic        push_ready;
  pmd_packet_t push_data;

  // Queue to back end
  logic        pop_valid;
  logic        pop_ready;
  pmd_packet_t pop_data;

  // Assemble, filter and classify packets
  pmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .byte_in        (byte_in),
    .push_ready     (push_ready),
    .push_valid     (push_valid),
    .push_data      (push_data)
  );

  // Hold decoded packets so either side can stall on its own
  pmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Issue the events of each packet in report order
  pmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .event_out (event_out)
  );

endmodule

FILE: tb/sv/tb_ps2_mouse_packet_decoder_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder testbench
// Feeds raw mouse bytes through the byte channel and decodes the same
// stream in a local packet assembler. Every event taken from the event
// channel is checked, field by field, against the oldest decoded event
// still outstanding. A disabled phase comes first, then directed packets:
// field extremes, all buttons, overflow, no change, a missing sync bit and
// disable. Random packet traffic follows under three idling patterns.
// ---------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder_unit;
  import pmd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // One decoded event as the event channel should carry it
  typedef struct {
    pmd_kind_t         kind;
    logic signed [8:0] value;
    logic              last;
  } mouse_event_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  pmd_byte_if  byte_ch ();
  pmd_event_if event_ch ();

  ps2_mouse_packet_decoder_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .byte_in        (byte_ch),
    .event_out      (event_ch)
  );

  // Local copy of the decoder state
  logic       decode_on;
  logic [1:0] byte_pos;
  logic [7:0] header_byte;
  logic [7:0] x_byte;
  logic [2:0] held_buttons;

  // Decoded events still to come out of the block, oldest first
  mouse_event_t pending_events[$];

  int fail_count;
  int cycle_count;
  int src_idle_pct;
  int sink_idle_pct;

  always #1 clk = ~clk;

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  function automatic void queue_event(input pmd_kind_t kind, input logic signed [8:0] value,
                                      input logic last);
    mouse_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.last  = last;
    pending_events.push_back(ev);
  endfunction

  // Advance the local assembler by one accepted byte and queue whatever
  // events the completed packet releases.
  function automatic void decode_mouse_byte(input logic [7:0] b);
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [2:0]        now_held;
    logic [2:0]        diff;
    // Disabled: drop the byte and rewind to the start of a packet
    if (!decode_on) begin
      byte_pos = 2'd0;
      return;
    end
    // Hunt for a header: drop anything without the sync bit
    if (byte_pos == 2'd0 && (b & SYNC_BIT) == 8'h00) return;
    if (byte_pos == 2'd0) begin
      header_byte = b;
      byte_pos    = 2'd1;
      return;
    end
    if (byte_pos == 2'd1) begin
      x_byte   = b;
      byte_pos = 2'd2;
      return;
    end
    // Third byte closes the packet
    byte_pos = 2'd0;
    if ((header_byte & OVERFLOW_BITS) != 8'h00) return;
    dx = $signed({x_byte[7], x_byte});
    dy = -$signed({b[7], b});
    now_held = 3'b000;
    now_held[HELD_LEFT]   = |(header_byte & SRC_LEFT);
    now_held[HELD_MIDDLE] = |(header_byte & SRC_MIDDLE);
    now_held[HELD_RIGHT]  = |(header_byte & SRC_RIGHT);
    diff = now_held ^ held_buttons;
    // Nothing moved and nothing changed: no report at all
    if (dx == 9'sd0 && dy == 9'sd0 && diff == 3'b000) return;
    held_buttons = now_held;
    if (dx != 9'sd0) queue_event(KIND_MOVE_X, dx, 1'b0);
    if (dy != 9'sd0) queue_event(KIND_MOVE_Y, dy, 1'b0);
    if (diff[HELD_LEFT])   queue_event(KIND_LEFT,   {8'd0, now_held[HELD_LEFT]},   1'b0);
    if (diff[HELD_RIGHT])  queue_event(KIND_RIGHT,  {8'd0, now_held[HELD_RIGHT]},  1'b0);
    if (diff[HELD_MIDDLE]) queue_event(KIND_MIDDLE, {8'd0, now_held[HELD_MIDDLE]}, 1'b0);
    queue_event(KIND_SYNC, 9'sd0, 1'b1);
  endfunction

  // Offer one byte request, idling first at the sender's rate, and hold it
  // until the block takes it. Called and returns at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.mouse_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_mouse_byte(b);
  endtask

  // Drop the byte request, drain every outstanding event, then give a
  // packet that produced nothing time to leave the pipeline.
  task automatic finish_phase();
    byte_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the enable register; only called with the block idle.
  task automatic set_decode_enable(input logic on);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= on;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    decode_on = on;
    if (!on) byte_pos = 2'd0;
  endtask

  // Disable, push random bytes that must all be dropped, re-enable.
  task automatic test_disabled_bytes(input int count);
    set_decode_enable(1'b0);
    repeat (count) send_byte(8'($urandom));
    finish_phase();
    set_decode_enable(1'b1);
  endtask

  task automatic test_directed_packets();
    // Left press, largest positive X, Y from -128 gives +128
    send_byte(8'h09); send_byte(8'h7f); send_byte(8'h80);
    // Left release, most negative X, Y from +127
    send_byte(8'h08); send_byte(8'h80); send_byte(8'h7f);
    // Every event at once: X, Y, all three buttons pressed, sync
    send_byte(8'h0f); send_byte(8'h01); send_byte(8'hff);
    // Same buttons, no movement: no report
    send_byte(8'h0f); send_byte(8'h00); send_byte(8'h00);
    // Overflow on either bit: packet dropped, held buttons kept
    send_byte(8'h48); send_byte(8'h05); send_byte(8'h05);
    send_byte(8'h88); send_byte(8'h05); send_byte(8'h05);
    // No sync bit at the start of a packet: dropped
    send_byte(8'hf7);
    finish_phase();
  endtask

  // Half a packet, then a disable write must throw it away; the next
  // header then starts cleanly (Y of -2, left and middle released).
  task automatic test_enable_clear();
    send_byte(8'h08); send_byte(8'h05);
    finish_phase();
    set_decode_enable(1'b0);
    set_decode_enable(1'b1);
    send_byte(8'h0a); send_byte(8'h00); send_byte(8'h02);
    finish_phase();
  endtask

  // Mostly well-formed packets with random buttons and movement; a few
  // overflow headers and stray bytes that knock the framing about.
  task automatic test_random_traffic(input int packets, input int src_pct, input int sink_pct);
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (packets) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom));
      end else begin
        hdr = 8'($urandom) | SYNC_BIT;
        if ($urandom_range(0, 9) != 0) hdr = hdr & ~OVERFLOW_BITS;
        dx = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        dy = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
      end
    end
    finish_phase();
  endtask

  // Take events at the receiver's rate and check each one as it is accepted.
  always @(posedge clk) begin : event_checker
    mouse_event_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        log_failure($sformatf("unexpected event: kind %0d value %0d last %0b",
                              event_ch.event_kind, event_ch.event_value,
                              event_ch.last_event));
      end else begin
        want = pending_events.pop_front();
        if (event_ch.event_kind !== want.kind || event_ch.event_value !== want.value ||
            event_ch.last_event !== want.last) begin
          log_failure($sformatf(
            "event mismatch: expected kind %0d value %0d last %0b, got kind %0d value %0d last %0b",
            want.kind, want.value, want.last, event_ch.event_kind,
            event_ch.event_value, event_ch.last_event));
        end
      end
    end
    event_ch.ready <= !rst && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_write_data     = 1'b0;
    byte_ch.valid      = 1'b0;
    byte_ch.mouse_byte = 8'h00;
    event_ch.ready     = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    decode_on          = 1'b0;
    byte_pos           = 2'd0;
    header_byte        = 8'h00;
    x_byte             = 8'h00;
    held_buttons       = 3'b000;
    src_idle_pct       = 26;
    sink_idle_pct      = 51;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_disabled_bytes(2);
    test_directed_packets();
    test_enable_clear();
    test_random_traffic(34, 26, 51);
    test_disabled_bytes(4);
    test_random_traffic(34, 51, 26);
    test_disabled_bytes(3);
    test_random_traffic(34, 0, 0);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: ps2_mouse_packet_decoder_unit.f
+incdir+sv
sv/pmd_pkg.sv
sv/pmd_if.sv
sv/pmd_front.sv
sv/pmd_queue.sv
sv/pmd_back.sv
sv/ps2_mouse_packet_decoder_unit.sv
tb/sv/tb_ps2_mouse_packet_decoder_unit.sv
